### rtl/core/double_ended_queue_macros.svh
// Assertion macros for the double-ended queue.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on every rising edge, skipped while reset is high.
`define DQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on every rising edge, reset included.
`define DQ_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DQ_ASSERT(label, clk, rst, prop, msg)
`define DQ_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

### rtl/core/dq_pkg.sv
package dq_pkg;

   localparam int DQ_DEPTH = 16;

   localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
   localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
   localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
   localparam logic [2:0] KIND_POP_BACK   = 3'd3;
   localparam logic [2:0] KIND_READ_ALL   = 3'd4;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_POP  = 3'b010,
      ST_DUMP = 3'b100
   } dq_state_type;

endpackage

### rtl/core/double_ended_queue.sv
// Channel  | Dir | Payload                                           | Handshake
// ---------+-----+---------------------------------------------------+---------------------
// request  | in  | req_kind, req_value                               | req_valid, req_stall
// response | out | rsp_status, rsp_element, rsp_fill_count, rsp_last | rsp_valid, rsp_stall
//
// A push, a refused push and any pop or read-out of an empty queue are answered from ST_IDLE.
// A pop passes through ST_POP: the ring store's single read port returns registered data.
// A read-out streams its entries from ST_DUMP, one store read per entry.
// Reset (synchronous, active high) empties the queue; the slots themselves are not cleared.
// A stalled response holds the block: no new request and no further read-out reads.
`include "double_ended_queue_macros.svh"

module double_ended_queue
   import dq_pkg::*;
#(
   parameter int DEPTH = DQ_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_kind,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_element,
   output logic [4:0]         rsp_fill_count,
   output logic               rsp_last
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;  // ring index
   localparam int CW = $clog2(DEPTH + 1);                // fill count 0..DEPTH

   // Ring position base + off, with off at most DEPTH.
   function automatic logic [IW-1:0] ring_pos(input logic [IW-1:0] base,
                                               input logic [CW-1:0] off);
      logic [CW:0] sum;
      sum = {{(CW + 1 - IW){1'b0}}, base} + {1'b0, off};
      if (sum >= (CW + 1)'(DEPTH)) begin
         sum = sum - (CW + 1)'(DEPTH);
      end
      return sum[IW-1:0];
   endfunction

   // Low five bits of a fill count.
   function automatic logic [4:0] fill5(input logic [CW-1:0] occ);
      logic [CW+4:0] wide;
      wide = {5'b0, occ};
      return wide[4:0];
   endfunction

   // Ring store: one write and one registered read per cycle.
   logic signed [31:0] slots_mem [DEPTH];
   logic signed [31:0] rd_data_ff;
   logic               wr_en;
   logic [IW-1:0]      wr_addr;
   logic               rd_en;
   logic [IW-1:0]      rd_addr;

   dq_state_type       state_ff, state_in;
   logic [IW-1:0]      front_ff, front_in;
   logic [CW-1:0]      occ_ff, occ_in;
   logic [CW-1:0]      dump_idx_ff, dump_idx_in;   // entry whose data sits in rd_data_ff

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic signed [31:0] rsp_element_ff, rsp_element_in;
   logic [4:0]         rsp_fill_ff, rsp_fill_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               out_free;
   logic               req_accept;
   logic               is_full;
   logic               is_empty;
   logic [CW-1:0]      dump_next;
   logic               req_push;
   logic               push_refused;
   logic               push_taken;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !((state_ff == ST_IDLE) && out_free);
   assign req_accept = req_valid && !req_stall;
   assign is_full    = (occ_ff >= CW'(DEPTH));
   assign is_empty   = (occ_ff == '0);
   assign dump_next  = dump_idx_ff + CW'(1);

   assign req_push     = (req_kind == KIND_PUSH_FRONT) || (req_kind == KIND_PUSH_BACK);
   assign push_refused = req_accept && req_push && is_full;
   assign push_taken   = req_accept && req_push && !is_full;

   always_comb begin
      state_in       = state_ff;
      front_in       = front_ff;
      occ_in         = occ_ff;
      dump_idx_in    = dump_idx_ff;
      wr_en          = 1'b0;
      wr_addr        = front_ff;
      rd_en          = 1'b0;
      rd_addr        = front_ff;
      // Drop the response once taken; a load below refills the register.
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_element_in = rsp_element_ff;
      rsp_fill_in    = rsp_fill_ff;
      rsp_last_in    = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_kind)
                  KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
                     rsp_valid_in   = 1'b1;
                     rsp_element_in = req_value;
                     rsp_last_in    = 1'b1;
                     if (is_full) begin
                        // Refuse the push, keep the state.
                        rsp_status_in = STATUS_FULL;
                        rsp_fill_in   = fill5(occ_ff);
                     end else begin
                        wr_en = 1'b1;
                        if (req_kind == KIND_PUSH_FRONT) begin
                           wr_addr  = ring_pos(front_ff, CW'(DEPTH - 1));
                           front_in = wr_addr;
                        end else begin
                           wr_addr = ring_pos(front_ff, occ_ff);
                        end
                        occ_in        = occ_ff + CW'(1);
                        rsp_status_in = STATUS_OK;
                        rsp_fill_in   = fill5(occ_ff + CW'(1));
                     end
                  end
                  KIND_POP_FRONT, KIND_POP_BACK, KIND_READ_ALL: begin
                     if (is_empty) begin
                        rsp_valid_in   = 1'b1;
                        rsp_status_in  = STATUS_EMPTY;
                        rsp_element_in = '0;
                        rsp_fill_in    = '0;
                        rsp_last_in    = 1'b1;
                     end else if (req_kind == KIND_READ_ALL) begin
                        // Read the front entry; stream the rest from ST_DUMP.
                        rd_en       = 1'b1;
                        rd_addr     = front_ff;
                        dump_idx_in = '0;
                        state_in    = ST_DUMP;
                     end else begin
                        rd_en = 1'b1;
                        if (req_kind == KIND_POP_FRONT) begin
                           rd_addr  = front_ff;
                           front_in = ring_pos(front_ff, CW'(1));
                        end else begin
                           rd_addr = ring_pos(front_ff, occ_ff - CW'(1));
                        end
                        occ_in   = occ_ff - CW'(1);
                        state_in = ST_POP;
                     end
                  end
                  default: begin
                     // Unused kind: drop the request, no response.
                  end
               endcase
            end
         end
         ST_POP: begin
            // Deliver the popped entry; occ_ff already holds the new count.
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = STATUS_OK;
               rsp_element_in = rd_data_ff;
               rsp_fill_in    = fill5(occ_ff);
               rsp_last_in    = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_DUMP: begin
            // Hold rd_data_ff until the response register frees, then advance.
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = STATUS_OK;
               rsp_element_in = rd_data_ff;
               rsp_fill_in    = fill5(occ_ff);
               rsp_last_in    = (dump_next == occ_ff);
               if (dump_next == occ_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_en       = 1'b1;
                  rd_addr     = ring_pos(front_ff, dump_next);
                  dump_idx_in = dump_next;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Store accesses come from separate requests, so a read never meets a
   // write to the same slot in the same cycle; no forwarding path is needed.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slots_mem[wr_addr] <= req_value;
      end
      if (rd_en) begin
         rd_data_ff <= slots_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         front_ff     <= '0;
         occ_ff       <= '0;
         dump_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         occ_ff       <= occ_in;
         dump_idx_ff  <= dump_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff  <= rsp_status_in;
      rsp_element_ff <= rsp_element_in;
      rsp_fill_ff    <= rsp_fill_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_element    = rsp_element_ff;
   assign rsp_fill_count = rsp_fill_ff;
   assign rsp_last       = rsp_last_ff;

   // Occupancy stays within the ring; the count is unknown until the first reset edge.
   `DQ_ASSERT_ALWAYS(a_occ_bound, clock, reset || (occ_ff <= CW'(DEPTH)), "occupancy beyond depth")

   // A read-out never walks past the held entries.
   `DQ_ASSERT(a_dump_bound, clock, reset, state_ff == ST_DUMP |-> dump_idx_ff < occ_ff, "dump overrun")

   // A refused push leaves the fill count alone.
   `DQ_ASSERT(a_full_hold, clock, reset, push_refused |=> $stable(occ_ff), "refused push moved fill")

   // An accepted push onto a non-full queue adds exactly one entry.
   `DQ_ASSERT(a_push_grow, clock, reset, push_taken |=> occ_ff == $past(occ_ff) + CW'(1), "push lost")

endmodule

### test/tb_double_ended_queue.sv
`timescale 1ns / 100ps

module tb_double_ended_queue
   import dq_pkg::*;
();

   // Timing and run shape.
   localparam int CLOCK_HALF     = 6;
   localparam int RANDOM_ITEMS   = 225;
   localparam int QUIET_TAIL     = 60;    // final requests run with no idling on either side
   localparam int DRAIN_CYCLES   = 20;
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake on either channel
   localparam int PHASE_LENGTH   = 40;    // requests per push-heavy or pop-heavy stretch

   // Kind codes that the block must ignore.
   localparam logic [2:0] KIND_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] KIND_UNUSED_LAST  = 3'd7;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] value;
   } deque_request_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] element;
      logic [4:0]  fill_count;
      logic        last;
   } deque_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [2:0]         req_kind = KIND_PUSH_FRONT;
   logic signed [31:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_element;
   logic [4:0]         rsp_fill_count;
   logic               rsp_last;

   // Requests waiting to be driven, and responses the ring model says are due.
   deque_request_type pending_requests[$];
   deque_result_type  awaited_results[$];

   // Ring model of the deque.
   logic [31:0] ring_slots [DQ_DEPTH];
   int          ring_front = 0;
   int          ring_count = 0;

   logic req_taken = 1'b0;
   int   gap_left = 0;
   int   stall_left = 0;
   int   mismatch_count = 0;
   int   idle_cycles = 0;

   double_ended_queue u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_element    (rsp_element),
      .rsp_fill_count (rsp_fill_count),
      .rsp_last       (rsp_last)
   );

   initial begin
      forever #(CLOCK_HALF) clock = ~clock;
   end

   function automatic deque_result_type make_result(logic [1:0] status, logic [31:0] element,
                                                    logic [4:0] fill_count, logic last);
      deque_result_type res;
      res.status     = status;
      res.element    = element;
      res.fill_count = fill_count;
      res.last       = last;
      return res;
   endfunction

   // Apply one accepted request to the ring model and queue the responses it causes.
   task automatic predict_deque(input logic [2:0] kind, input logic [31:0] value);
      logic [31:0] taken;
      case (kind)
         KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
            if (ring_count >= DQ_DEPTH) begin
               // Refuse the push: state holds, the offered value comes back.
               awaited_results.push_back(make_result(STATUS_FULL, value, 5'(ring_count), 1'b1));
            end else begin
               if (kind == KIND_PUSH_FRONT) begin
                  ring_front = (ring_front + DQ_DEPTH - 1) % DQ_DEPTH;
                  ring_slots[ring_front] = value;
               end else begin
                  ring_slots[(ring_front + ring_count) % DQ_DEPTH] = value;
               end
               ring_count++;
               awaited_results.push_back(make_result(STATUS_OK, value, 5'(ring_count), 1'b1));
            end
         end
         KIND_POP_FRONT, KIND_POP_BACK: begin
            if (ring_count == 0) begin
               awaited_results.push_back(make_result(STATUS_EMPTY, '0, '0, 1'b1));
            end else begin
               if (kind == KIND_POP_FRONT) begin
                  taken = ring_slots[ring_front];
                  ring_front = (ring_front + 1) % DQ_DEPTH;
               end else begin
                  taken = ring_slots[(ring_front + ring_count - 1) % DQ_DEPTH];
               end
               ring_count--;
               awaited_results.push_back(make_result(STATUS_OK, taken, 5'(ring_count), 1'b1));
            end
         end
         KIND_READ_ALL: begin
            if (ring_count == 0) begin
               awaited_results.push_back(make_result(STATUS_EMPTY, '0, '0, 1'b1));
            end else begin
               // Walk front to back; mark the final entry.
               for (int i = 0; i < ring_count; i++) begin
                  awaited_results.push_back(make_result(STATUS_OK,
                     ring_slots[(ring_front + i) % DQ_DEPTH], 5'(ring_count),
                     i == ring_count - 1));
               end
            end
         end
         default: begin
            // Drop unused kinds: no response, no change of state.
         end
      endcase
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'h0000_0000;
         3:       return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // Request driver: change inputs on the falling edge, hold the payload while stalled.
   always @(negedge clock) begin
      deque_request_type next_req;
      if (reset || (req_valid && !req_taken)) begin
         // Hold the current request until it is accepted.
      end else if (gap_left != 0) begin
         gap_left--;
         req_valid <= 1'b0;
      end else if (pending_requests.size() != 0) begin
         next_req = pending_requests.pop_front();
         req_valid <= 1'b1;
         req_kind  <= next_req.kind;
         req_value <= next_req.value;
         // Start an idle burst after this request, except in the quiet tail.
         if (pending_requests.size() >= QUIET_TAIL && $urandom_range(0, 7) == 0)
            gap_left = $urandom_range(1, 15);
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Response back-pressure: random stall bursts, none in the quiet tail.
   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!reset && pending_requests.size() >= QUIET_TAIL
                   && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 14);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: sample both channels on the rising edge; predict first, then check.
   always @(posedge clock) begin
      deque_result_type want;
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall)
         predict_deque(req_kind, req_value);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_results.size() == 0) begin
            report_mismatch("unexpected response element", rsp_element, '0);
         end else begin
            want = awaited_results.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_element !== want.element)
               report_mismatch("element", rsp_element, want.element);
            if (rsp_fill_count !== want.fill_count)
               report_mismatch("fill count", rsp_fill_count, want.fill_count);
            if (rsp_last !== want.last)
               report_mismatch("last", rsp_last, want.last);
         end
      end
   end

   // Watchdog: end the run if neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      int roll;
      logic push_heavy;

      // Empty queue: both pops and the read-out report empty; unused kinds vanish.
      pending_requests.push_back('{KIND_POP_FRONT, 32'h1234_5678});
      pending_requests.push_back('{KIND_POP_BACK, 32'hffff_ffff});
      pending_requests.push_back('{KIND_READ_ALL, 32'h0});
      pending_requests.push_back('{KIND_UNUSED_FIRST, 32'h5555_5555});
      pending_requests.push_back('{KIND_UNUSED_LAST, 32'haaaa_aaaa});
      // Fill to capacity from both ends (front push wraps the ring), then refuse two more.
      for (int i = 0; i < DQ_DEPTH + 2; i++) begin
         case (i % 4)
            0: pending_requests.push_back('{KIND_PUSH_FRONT, 32'h8000_0000 + i});
            1: pending_requests.push_back('{KIND_PUSH_BACK, 32'h7fff_ffff - i});
            2: pending_requests.push_back('{KIND_PUSH_FRONT, 32'(i)});
            default: pending_requests.push_back('{KIND_PUSH_BACK, ~32'(i)});
         endcase
      end
      // Read out the full queue, then pop from each end.
      pending_requests.push_back('{KIND_READ_ALL, 32'h0});
      pending_requests.push_back('{KIND_POP_FRONT, 32'h0});
      pending_requests.push_back('{KIND_POP_BACK, 32'h0});

      // Random part: alternate push-heavy and pop-heavy stretches so the queue
      // swings between full and empty.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         push_heavy = ((n / PHASE_LENGTH) % 2) == 0;
         roll = $urandom_range(0, 99);
         if (roll < 3)
            pending_requests.push_back('{3'($urandom_range(KIND_UNUSED_FIRST,
                                                            KIND_UNUSED_LAST)), pick_value()});
         else if (roll < 13)
            pending_requests.push_back('{KIND_READ_ALL, pick_value()});
         else if (roll < (push_heavy ? 68 : 38))
            pending_requests.push_back('{$urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT,
                                         pick_value()});
         else
            pending_requests.push_back('{$urandom_range(0, 1) ? KIND_POP_BACK : KIND_POP_FRONT,
                                         pick_value()});
      end

      // Hold reset, then release it on a falling edge.
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Wait for every request to go in and every response to come back.
      while (pending_requests.size() != 0 || req_valid || awaited_results.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

### files.f
+incdir+rtl/core
rtl/core/dq_pkg.sv
rtl/core/double_ended_queue.sv
test/tb_double_ended_queue.sv
